[rtl/gsa_pkg.sv]
package gsa_pkg;

    // sizes
    localparam int SLOTS     = 8192;
    localparam int TYPES     = 8;
    localparam int GEN_BITS  = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int DEPTH_W   = $clog2(SLOTS + 1);
    localparam int TYPE_W    = 3;
    localparam int TIDX_W    = (TYPES > 1) ? $clog2(TYPES) : 1;
    localparam int CNT_W     = 14;
    localparam int CFG_W     = 14;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 3;
    localparam int UNIT_W    = (GEN_BITS > DEPTH_W) ?
                               ((GEN_BITS > CNT_W) ? GEN_BITS : CNT_W) :
                               ((DEPTH_W > CNT_W) ? DEPTH_W : CNT_W);
    localparam int CAP_RESET = 6000;
    localparam int CAP_INIT  = (CAP_RESET < SLOTS) ? CAP_RESET : SLOTS;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEL = 2'd1;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_STALE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_TYPE   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOSLOT = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd5;

    typedef logic [TYPE_W-1:0]   t_type;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [GEN_BITS-1:0] t_gen;
    typedef logic [DEPTH_W-1:0]  t_depth;
    typedef logic [CNT_W-1:0]    t_count;
    typedef logic [UNIT_W-1:0]   t_unit;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        t_type            entity_type;
        t_slot            slot;
        t_gen             generation;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_slot             out_slot;
        t_gen              out_generation;
        t_type             out_type;
        t_slot             position_in_type;
    } t_rsp;

    // one entry of the per-slot store
    typedef struct packed {
        t_type etype;
        t_gen  gen;
        t_slot pos;
    } t_slot_word;

    typedef struct packed {
        logic       slot_we;
        t_slot      slot_waddr;
        t_slot_word slot_wdata;
        t_slot      slot_raddr;
        logic       stk_we;
        t_slot      stk_waddr;
        t_slot      stk_wdata;
        t_slot      stk_raddr;
    } t_mem_req;

    typedef struct packed {
        t_unit a;
        t_unit b;
        logic  sub;
    } t_alu_req;

    typedef struct packed {
        t_unit sum;
        logic  lt;
    } t_alu_rsp;

    function automatic logic type_ok(t_type t);
        return 32'(t) < TYPES;
    endfunction

endpackage

[rtl/gsa_if.sv]
interface gsa_req_if;
    import gsa_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gsa_rsp_if;
    import gsa_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/gsa_alu.sv]
module gsa_alu (
    input  gsa_pkg::t_alu_req i_req,
    output gsa_pkg::t_alu_rsp o_rsp
);
    import gsa_pkg::*;

    logic [UNIT_W:0] w_full;
    t_unit           w_b;

    // one adder: a + b, or a - b with borrow giving a < b
    assign w_b    = i_req.sub ? ~i_req.b : i_req.b;
    assign w_full = {1'b0, i_req.a} + {1'b0, w_b} + {{UNIT_W{1'b0}}, i_req.sub};
    assign o_rsp.sum = w_full[UNIT_W-1:0];
    assign o_rsp.lt  = i_req.sub & ~w_full[UNIT_W];

endmodule

[rtl/gsa_store.sv]
module gsa_store (
    input  logic                i_clk,
    input  gsa_pkg::t_mem_req   i_req,
    output gsa_pkg::t_slot_word o_slot_q,
    output gsa_pkg::t_slot      o_stk_q
);
    import gsa_pkg::*;

    t_slot_word r_slot_mem [SLOTS];
    t_slot      r_stk_mem  [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_req.slot_we) begin
            r_slot_mem[i_req.slot_waddr] <= i_req.slot_wdata;
        end
        o_slot_q <= r_slot_mem[i_req.slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.stk_we) begin
            r_stk_mem[i_req.stk_waddr] <= i_req.stk_wdata;
        end
        o_stk_q <= r_stk_mem[i_req.stk_raddr];
    end

endmodule

[rtl/generational_slot_allocator.sv]
// channel  dir  word   handshake    contents
// i_req    in   t_req  valid/ready  action, entity_type, slot, generation
// o_rsp    out  t_rsp  valid/ready  status, out_slot, out_generation, out_type, position
// i_cfg    in   14 b   write enable slot_capacity, no read-back
//
// one word at a time: lookup goes check, compare, done; delete goes check,
// stack push, count, done; add goes check, pop or fresh, update, count, done;
// range, type and capacity errors go check, done; a full stack check, push, done.
// the steps share the one add/compare unit and the slot and stack
// memories, each with one registered read.
// after reset a clearing pass zeroes the slot memory; i_req is not ready
// meanwhile. a finished word waits in the output register while o_rsp is
// stalled; the next word is taken as soon as the sequencer is idle.
module generational_slot_allocator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gsa_pkg::CFG_W-1:0]   i_cfg_wdata,
    gsa_req_if.sink                     i_req,
    gsa_rsp_if.source                   o_rsp
);
    import gsa_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_POP   = 4'd3;
    localparam logic [3:0] S_FRESH = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_CNT   = 4'd6;
    localparam logic [3:0] S_DSTK  = 4'd7;
    localparam logic [3:0] S_DCNT  = 4'd8;
    localparam logic [3:0] S_LCMP  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0] r_state, n_state;
    t_req       r_in, n_in;
    t_slot      r_slot, n_slot;
    t_depth     r_depth, n_depth;
    t_depth     r_fresh, n_fresh;
    t_depth     r_cap;
    t_count     r_count [TYPES];
    t_count     n_count [TYPES];
    t_slot      r_clr, n_clr;
    t_rsp       r_res, n_res;
    t_rsp       r_out, n_out;
    logic       r_out_valid, n_out_valid;

    t_mem_req   w_mem;
    t_slot_word w_slot_q;
    t_slot      w_stk_q;
    t_alu_req   w_alu_req;
    t_alu_rsp   w_alu;
    logic [TIDX_W-1:0] w_tidx;
    t_count     w_cnt;

    gsa_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu)
    );

    gsa_store u_store (
        .i_clk    (i_clk),
        .i_req    (w_mem),
        .o_slot_q (w_slot_q),
        .o_stk_q  (w_stk_q)
    );

    assign w_tidx      = r_in.entity_type[TIDX_W-1:0];
    assign w_cnt       = r_count[w_tidx];
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_slot      = r_slot;
        n_depth     = r_depth;
        n_fresh     = r_fresh;
        n_count     = r_count;
        n_clr       = r_clr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        w_alu_req   = '0;
        w_mem       = '0;
        case (r_state)
            S_CLR: begin
                w_mem.slot_we    = 1'b1;
                w_mem.slot_waddr = r_clr;
                n_clr            = r_clr + 1'b1;
                if (r_clr == t_slot'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_in    = i_req.data;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_res = '{status: ST_OK, out_slot: r_in.slot, out_generation: '0,
                          out_type: r_in.entity_type, position_in_type: '0};
                if (r_in.action == ACT_ADD) begin
                    n_res = '0;
                    if (!type_ok(r_in.entity_type)) begin
                        n_res.status = ST_TYPE;
                        n_state      = S_DONE;
                    end else if (r_depth != '0) begin
                        w_alu_req        = '{a: t_unit'(r_depth), b: t_unit'(1), sub: 1'b1};
                        n_depth          = w_alu.sum[DEPTH_W-1:0];
                        w_mem.stk_raddr  = w_alu.sum[SLOT_W-1:0];
                        n_state          = S_POP;
                    end else begin
                        w_alu_req = '{a: t_unit'(r_fresh), b: t_unit'(r_cap), sub: 1'b1};
                        if (w_alu.lt) begin
                            n_slot  = r_fresh[SLOT_W-1:0];
                            n_state = S_FRESH;
                        end else begin
                            n_res.status = ST_NOSLOT;
                            n_state      = S_DONE;
                        end
                    end
                end else if (r_in.action == ACT_DEL) begin
                    w_alu_req = '{a: t_unit'(r_in.slot), b: t_unit'(r_cap), sub: 1'b1};
                    if (!type_ok(r_in.entity_type)) begin
                        n_res.status = ST_TYPE;
                        n_state      = S_DONE;
                    end else if (!w_alu.lt) begin
                        n_res.status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_DSTK;
                    end
                end else begin
                    n_res.out_generation = r_in.generation;
                    w_alu_req = '{a: t_unit'(r_in.slot), b: t_unit'(r_cap), sub: 1'b1};
                    if (!w_alu.lt) begin
                        n_res.status = ST_RANGE;
                        n_state      = S_DONE;
                    end else begin
                        w_mem.slot_raddr = r_in.slot;
                        n_state          = S_LCMP;
                    end
                end
            end
            S_POP: begin
                n_slot           = w_stk_q;
                w_mem.slot_raddr = w_stk_q;
                n_state          = S_UPD;
            end
            S_FRESH: begin
                w_alu_req        = '{a: t_unit'(r_fresh), b: t_unit'(1), sub: 1'b0};
                n_fresh          = w_alu.sum[DEPTH_W-1:0];
                w_mem.slot_raddr = r_slot;
                n_state          = S_UPD;
            end
            S_UPD: begin
                // generation wraps at its own width
                w_alu_req        = '{a: t_unit'(w_slot_q.gen), b: t_unit'(1), sub: 1'b0};
                w_mem.slot_we    = 1'b1;
                w_mem.slot_waddr = r_slot;
                w_mem.slot_wdata = '{etype: r_in.entity_type,
                                     gen: w_alu.sum[GEN_BITS-1:0],
                                     pos: w_cnt[SLOT_W-1:0]};
                n_res = '{status: ST_OK, out_slot: r_slot,
                          out_generation: w_alu.sum[GEN_BITS-1:0],
                          out_type: r_in.entity_type,
                          position_in_type: w_cnt[SLOT_W-1:0]};
                n_state = S_CNT;
            end
            S_CNT: begin
                w_alu_req       = '{a: t_unit'(w_cnt), b: t_unit'(1), sub: 1'b0};
                n_count[w_tidx] = w_alu.sum[CNT_W-1:0];
                n_state         = S_DONE;
            end
            S_DSTK: begin
                if (r_depth == t_depth'(SLOTS)) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    w_mem.stk_we    = 1'b1;
                    w_mem.stk_waddr = r_depth[SLOT_W-1:0];
                    w_mem.stk_wdata = r_in.slot;
                    w_alu_req       = '{a: t_unit'(r_depth), b: t_unit'(1), sub: 1'b0};
                    n_depth         = w_alu.sum[DEPTH_W-1:0];
                    n_state         = S_DCNT;
                end
            end
            S_DCNT: begin
                // live count wraps on underflow
                w_alu_req       = '{a: t_unit'(w_cnt), b: t_unit'(1), sub: 1'b1};
                n_count[w_tidx] = w_alu.sum[CNT_W-1:0];
                n_state         = S_DONE;
            end
            S_LCMP: begin
                if (w_slot_q.gen != r_in.generation) begin
                    n_res.status = ST_STALE;
                end else if (w_slot_q.etype != r_in.entity_type) begin
                    n_res.status = ST_TYPE;
                end else begin
                    n_res.position_in_type = w_slot_q.pos;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_depth     <= '0;
            r_fresh     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= t_depth'(CAP_INIT);
            for (int i = 0; i < TYPES; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_fresh     <= n_fresh;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            if (i_cfg_we) begin
                r_cap <= (32'(i_cfg_wdata) > SLOTS) ? t_depth'(SLOTS)
                                                    : t_depth'(i_cfg_wdata);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_slot <= n_slot;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule

[rtl/gsa_checker.sv]
module gsa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          i_req_ready,
    input logic          i_rsp_valid,
    input logic          i_rsp_ready,
    input gsa_pkg::t_rsp i_rsp_data
);
    import gsa_pkg::*;

    // clearing pass follows every reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready && !i_rsp_valid)
        else $error("ready or valid right after reset");

    // one word in flight: no second accept on the next edge
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("input taken while a word is in work");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.status <= ST_FULL))
        else $error("status code out of range");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled result word changed");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
